/* hw/rtl/mcct_pkg.sv */
// ----------------------------------------------------------------------------
// mcct_pkg
// Shared codes and constants of the modem command character translator.
// ----------------------------------------------------------------------------
package mcct_pkg;

    // character and field widths
    localparam int CHAR_W   = 8;
    localparam int ACTION_W = 2;
    localparam int IDX_W    = 3;
    localparam int OUT_W    = 16;

    // line actions
    localparam logic [ACTION_W-1:0] ACT_SEND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PAUSE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BREAK = 2'd2;

    // fixed characters
    localparam logic [CHAR_W-1:0] CH_BACKSLASH  = 8'd92;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'd95;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'd13;
    localparam logic [CHAR_W-1:0] CH_ESC        = 8'd27;
    localparam logic [CHAR_W-1:0] CTRL_LOWER    = 8'd96;
    localparam logic [CHAR_W-1:0] CTRL_UPPER    = 8'd64;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PAUSE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RETURN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PREFIX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ESCAPE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BREAK   = 3'd4;
    localparam logic [IDX_W-1:0] REG_PACE    = 3'd5;

    // register reset values
    localparam logic [CHAR_W-1:0] RST_PAUSE  = 8'd126;
    localparam logic [CHAR_W-1:0] RST_RETURN = 8'd33;
    localparam logic [CHAR_W-1:0] RST_PREFIX = 8'd94;
    localparam logic [CHAR_W-1:0] RST_ESCAPE = 8'd36;
    localparam logic [CHAR_W-1:0] RST_BREAK  = 8'd37;

endpackage

/* hw/rtl/modem_command_char_translator_top.sv */
// ----------------------------------------------------------------------------
// modem_command_char_translator_top
// Turns modem command characters into send, pause and break line actions.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tdata: in_char, tlast: end_of_string
//  m_axis    out        tdata: out_byte, pace_after; tuser: action
//  cfg       in         cfg_index: register, cfg_data: value
//
//  one character a cycle while the result side does not stall; each character
//  passes from input word to result word (input register, then result register)
//  characters that give no result still pass through the input register
//  reset clears pending literal/control state and loads register defaults
//  a stalled result holds the result register; a character with no result
//  still drains while the result waits
// ----------------------------------------------------------------------------
module modem_command_char_translator_top
    import mcct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [CHAR_W-1:0]   s_axis_tdata,   // [7:0] in_char
    input  logic                s_axis_tlast,   // end_of_string
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // [7:0] out_byte, [8] pace_after, rest zero
    output logic [ACTION_W-1:0] m_axis_tuser,   // [1:0] action
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CHAR_W-1:0]   cfg_data
);

    // configuration registers
    logic [CHAR_W-1:0] pause_reg, return_reg, prefix_reg, escape_reg, break_reg;
    logic              pace_reg;

    // input stage
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // translator state
    logic literal_reg, literal_next;
    logic control_reg, control_next;

    // result stage
    logic                out_valid_reg;
    logic [ACTION_W-1:0] out_action_reg;
    logic [CHAR_W-1:0]   out_byte_reg;
    logic                out_pace_reg;

    // combinational results
    logic                has_result;
    logic [ACTION_W-1:0] res_action;
    logic [CHAR_W-1:0]   res_byte;
    logic                res_pace;
    logic [CHAR_W-1:0]   ctl_byte;
    logic [CHAR_W-1:0]   ret_char;
    logic [CHAR_W-1:0]   fin_char;
    logic [CHAR_W-1:0]   esc_byte;
    logic                advance;
    logic                out_free;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_reg  <= RST_PAUSE;
            return_reg <= RST_RETURN;
            prefix_reg <= RST_PREFIX;
            escape_reg <= RST_ESCAPE;
            break_reg  <= RST_BREAK;
            pace_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PAUSE:  pause_reg  <= cfg_data;
                REG_RETURN: return_reg <= cfg_data;
                REG_PREFIX: prefix_reg <= cfg_data;
                REG_ESCAPE: escape_reg <= cfg_data;
                REG_BREAK:  break_reg  <= cfg_data;
                REG_PACE:   pace_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // handshake between the stages
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // character translation
    assign ctl_byte = (in_char_reg > CH_UNDERSCORE) ? (in_char_reg - CTRL_LOWER)
                                                    : (in_char_reg - CTRL_UPPER);
    assign ret_char = (in_char_reg == return_reg) ? CH_CR : in_char_reg;
    assign fin_char = control_reg ? ctl_byte : ret_char;
    assign esc_byte = (fin_char == escape_reg) ? CH_ESC : fin_char;

    always_comb
    begin
        has_result   = 1'b1;
        res_action   = ACT_SEND;
        res_byte     = '0;
        res_pace     = 1'b0;
        literal_next = 1'b0;
        control_next = 1'b0;
        if (literal_reg)
        begin
            res_byte = in_char_reg;
            res_pace = pace_reg;
        end
        else if (!control_reg && in_char_reg == CH_BACKSLASH)
        begin
            has_result   = 1'b0;
            literal_next = 1'b1;
        end
        else if (!control_reg && in_char_reg == pause_reg)
        begin
            res_action = ACT_PAUSE;
        end
        else if (!control_reg && ret_char == prefix_reg)
        begin
            has_result   = 1'b0;
            control_next = 1'b1;
        end
        else if (esc_byte == break_reg)
        begin
            res_action = ACT_BREAK;
        end
        else
        begin
            res_byte = esc_byte;
            res_pace = pace_reg;
        end
        // end of string drops pending state
        if (in_last_reg)
        begin
            literal_next = 1'b0;
            control_next = 1'b0;
        end
    end

    // pending state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            literal_reg <= 1'b0;
            control_reg <= 1'b0;
        end
        else if (advance)
        begin
            literal_reg <= literal_next;
            control_reg <= control_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && has_result)
        begin
            out_action_reg <= res_action;
            out_byte_reg   <= res_byte;
            out_pace_reg   <= res_pace;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {{(OUT_W-CHAR_W-1){1'b0}}, out_pace_reg, out_byte_reg};

endmodule

/* hw/rtl/mcct_checker.sv */
// ----------------------------------------------------------------------------
// mcct_checker
// Port-level checks of the modem command character translator.
// ----------------------------------------------------------------------------
module mcct_checker
    import mcct_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [CHAR_W-1:0]   s_axis_tdata,
    input logic                s_axis_tlast,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_W-1:0]    m_axis_tdata,
    input logic [ACTION_W-1:0] m_axis_tuser,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [IDX_W-1:0]    cfg_index,
    input logic [CHAR_W-1:0]   cfg_data
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // only defined actions leave the block
    a_action: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
        (m_axis_tuser == ACT_SEND || m_axis_tuser == ACT_PAUSE || m_axis_tuser == ACT_BREAK))
        else $error("undefined action");

    // pause and break carry no byte and no pacing
    a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_SEND |-> m_axis_tdata == '0)
        else $error("pause or break with payload");

    // padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:CHAR_W+1] == '0)
        else $error("nonzero padding");

    // empty input stage always takes a word
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!s_axis_tvalid) && $past(s_axis_tready) |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule

bind modem_command_char_translator_top mcct_checker u_mcct_checker (.*);

/* tb/modem_command_char_translator_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modem_command_char_translator_top_tb
// Streams command strings into the translator under several synonym register
// settings. A software copy of the translation rules predicts every line
// action, and each output word is compared field by field with the oldest
// prediction. Both stream sides pause at random, and the receiver holds off
// once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module modem_command_char_translator_top_tb;
    import mcct_pkg::*;

    // spare register indexes, writes there must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE7 = 3'd7;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_CHARS  = 180;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } cmd_char_t;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   out_byte;
        logic                pace_after;
    } line_act_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [CHAR_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic [ACTION_W-1:0] m_axis_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CHAR_W-1:0]   cfg_data = '0;

    modem_command_char_translator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the synonym registers and the pending state
    logic [CHAR_W-1:0] sh_pause  = RST_PAUSE;
    logic [CHAR_W-1:0] sh_return = RST_RETURN;
    logic [CHAR_W-1:0] sh_prefix = RST_PREFIX;
    logic [CHAR_W-1:0] sh_escape = RST_ESCAPE;
    logic [CHAR_W-1:0] sh_break  = RST_BREAK;
    logic              sh_pace   = 1'b0;
    logic              literal_armed = 1'b0;
    logic              control_armed = 1'b0;

    cmd_char_t  char_q[$];
    line_act_t  action_q[$];
    int         chars_queued = 0;
    int         err_cnt = 0;

    logic       hold_kick = 1'b0;
    logic       hold_done = 1'b0;

    // escape substitution, then break or send
    function automatic line_act_t send_or_break(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = c;
        if (v == sh_escape)
            v = CH_ESC;
        if (v == sh_break)
            return '{action: ACT_BREAK, out_byte: '0, pace_after: 1'b0};
        return '{action: ACT_SEND, out_byte: v, pace_after: sh_pace};
    endfunction

    // translate one accepted character into its expected line action
    task automatic translate_char(input logic [CHAR_W-1:0] ch, input logic last);
        line_act_t         r;
        logic [CHAR_W-1:0] c;
        logic              gives;
        c = ch;
        gives = 1'b0;
        if (literal_armed)
        begin
            literal_armed = 1'b0;
            r = '{action: ACT_SEND, out_byte: c, pace_after: sh_pace};
            gives = 1'b1;
        end
        else if (control_armed)
        begin
            control_armed = 1'b0;
            c = (c > CH_UNDERSCORE) ? c - CTRL_LOWER : c - CTRL_UPPER;
            r = send_or_break(c);
            gives = 1'b1;
        end
        else if (c == CH_BACKSLASH)
            literal_armed = 1'b1;
        else if (c == sh_pause)
        begin
            r = '{action: ACT_PAUSE, out_byte: '0, pace_after: 1'b0};
            gives = 1'b1;
        end
        else
        begin
            if (c == sh_return)
                c = CH_CR;
            if (c == sh_prefix)
                control_armed = 1'b1;
            else
            begin
                r = send_or_break(c);
                gives = 1'b1;
            end
        end
        // end of string drops anything pending
        if (last)
        begin
            literal_armed = 1'b0;
            control_armed = 1'b0;
        end
        if (gives)
            action_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // input driver
    cmd_char_t tx_cur;
    int        tx_gap = 0;
    logic      tx_fast = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                translate_char(tx_cur.ch, tx_cur.last);
                tx_gap = tx_fast ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 39) == 0)
                    tx_fast = !tx_fast;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (char_q.size() > 0)
                begin
                    tx_cur = char_q.pop_front();
                    s_axis_tdata  <= tx_cur.ch;
                    s_axis_tlast  <= tx_cur.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output ready, with random waits and one long hold-off
    int   rx_wait = 0;
    int   hold_cnt = 0;
    logic rx_fast = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
            hold_cnt = 0;
        end
        else
        begin
            if (hold_kick && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_cnt = HOLD_CYCLES;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                rx_wait = rx_fast ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 39) == 0)
                    rx_fast = !rx_fast;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // output monitor
    line_act_t rx_want;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (action_q.size() == 0)
                report_mismatch("word with nothing expected", int'(m_axis_tdata), 0);
            else
            begin
                rx_want = action_q.pop_front();
                if (m_axis_tuser != rx_want.action)
                    report_mismatch("action", int'(m_axis_tuser), int'(rx_want.action));
                if (m_axis_tdata[CHAR_W-1:0] != rx_want.out_byte)
                    report_mismatch("out_byte", int'(m_axis_tdata[CHAR_W-1:0]),
                                    int'(rx_want.out_byte));
                if (m_axis_tdata[CHAR_W] != rx_want.pace_after)
                    report_mismatch("pace_after", int'(m_axis_tdata[CHAR_W]),
                                    int'(rx_want.pace_after));
                if (m_axis_tdata[OUT_W-1:CHAR_W+1] != '0)
                    report_mismatch("tdata padding", int'(m_axis_tdata[OUT_W-1:CHAR_W+1]), 0);
            end
        end
    end

    // watchdog on cycles without any handshake
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
        char_q.push_back('{ch: ch, last: last});
        chars_queued++;
    endtask

    // one register write on the config channel, shadow follows on the handshake
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PAUSE:  sh_pause  = val;
            REG_RETURN: sh_return = val;
            REG_PREFIX: sh_prefix = val;
            REG_ESCAPE: sh_escape = val;
            REG_BREAK:  sh_break  = val;
            REG_PACE:   sh_pace   = val[0];
            default:    ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [CHAR_W-1:0] p, input logic [CHAR_W-1:0] r,
                                input logic [CHAR_W-1:0] c, input logic [CHAR_W-1:0] e,
                                input logic [CHAR_W-1:0] b, input logic [CHAR_W-1:0] pace);
        write_reg(REG_PAUSE, p);
        write_reg(REG_RETURN, r);
        write_reg(REG_PREFIX, c);
        write_reg(REG_ESCAPE, e);
        write_reg(REG_BREAK, b);
        write_reg(REG_PACE, pace);
    endtask

    // wait until every character is in and every action is out
    task automatic drain_and_settle();
        do
            @(posedge clk);
        while (char_q.size() != 0 || s_axis_tvalid || action_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // synonym codes lean toward values that collide with fixed characters
    function automatic logic [CHAR_W-1:0] pick_code();
        if ($urandom_range(0, 2) == 0)
            return CHAR_W'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
            0:       return 8'd0;
            1:       return CH_CR;
            2:       return CH_ESC;
            3:       return RST_RETURN;
            4:       return RST_ESCAPE;
            5:       return RST_BREAK;
            6:       return CH_BACKSLASH;
            7:       return RST_PREFIX;
            8:       return CH_UNDERSCORE;
            9:       return CTRL_LOWER;
            10:      return RST_PAUSE;
            default: return 8'd255;
        endcase
    endfunction

    // command characters drawn mostly from the current synonyms
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 11))
            0:       return sh_pause;
            1:       return sh_return;
            2:       return sh_prefix;
            3:       return sh_escape;
            4:       return sh_break;
            5:       return CH_BACKSLASH;
            6:       return sh_escape + ($urandom_range(0, 1) ? CTRL_LOWER : CTRL_UPPER);
            7:       return sh_break + ($urandom_range(0, 1) ? CTRL_LOWER : CTRL_UPPER);
            8:       return $urandom_range(0, 1) ? CH_UNDERSCORE : CTRL_LOWER;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly terminated command strings, some loose noise characters
    task automatic queue_random_strings(input int count);
        int start;
        int len;
        start = chars_queued;
        while (chars_queued - start < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    push_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    push_char(pick_char(), i == len - 1);
            end
        end
    endtask

    // stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings under the reset synonyms
        push_char(8'd0, 1'b0);
        push_char(8'd255, 1'b1);
        push_char(CH_BACKSLASH, 1'b0);      // literal pause code
        push_char(RST_PAUSE, 1'b0);
        push_char(RST_PAUSE, 1'b0);         // pause
        push_char(RST_RETURN, 1'b0);        // carriage return
        push_char(RST_PREFIX, 1'b0);        // lower case control
        push_char(8'd97, 1'b0);
        push_char(RST_PREFIX, 1'b0);        // control boundary above underscore
        push_char(CTRL_LOWER, 1'b0);
        push_char(RST_PREFIX, 1'b0);        // underscore itself
        push_char(CH_UNDERSCORE, 1'b0);
        push_char(RST_PREFIX, 1'b0);        // control wraps below zero
        push_char(8'd0, 1'b0);
        push_char(RST_PREFIX, 1'b0);        // control result hits escape
        push_char(RST_ESCAPE + CTRL_LOWER, 1'b0);
        push_char(RST_PREFIX, 1'b0);        // control result hits break
        push_char(RST_BREAK + CTRL_LOWER, 1'b1);
        push_char(RST_ESCAPE, 1'b0);
        push_char(RST_BREAK, 1'b0);
        push_char(CH_BACKSLASH, 1'b1);      // trailing backslash dropped
        push_char(RST_PAUSE, 1'b0);
        push_char(RST_PREFIX, 1'b1);        // trailing prefix dropped
        push_char(8'd97, 1'b0);
        push_char(CH_BACKSLASH, 1'b0);      // literal backslash
        push_char(CH_BACKSLASH, 1'b0);
        push_char(RST_PREFIX, 1'b0);        // backslash after prefix is a control
        push_char(CH_BACKSLASH, 1'b1);
        drain_and_settle();

        // all synonyms at zero
        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_random_strings(PHASE_CHARS);
        drain_and_settle();

        // all synonyms at the top value, pacing on
        program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFF);
        queue_random_strings(PHASE_CHARS);
        drain_and_settle();

        // return feeds the prefix, escape result is the break code
        program_regs(RST_PAUSE, RST_RETURN, CH_CR, CH_ESC, CH_ESC, 8'd1);
        push_char(RST_RETURN, 1'b0);
        push_char(8'd97, 1'b0);
        push_char(CH_ESC, 1'b1);
        queue_random_strings(PHASE_CHARS);
        drain_and_settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            program_regs(pick_code(), pick_code(), pick_code(), pick_code(), pick_code(),
                         CHAR_W'($urandom_range(0, 255)));
            if (ph == 1)
            begin
                write_reg(REG_SPARE6, CHAR_W'($urandom_range(0, 255)));
                write_reg(REG_SPARE7, CHAR_W'($urandom_range(0, 255)));
            end
            if (ph == 2)
            begin
                @(posedge clk);
                hold_kick <= 1'b1;
            end
            queue_random_strings(PHASE_CHARS);
            drain_and_settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (action_q.size() != 0)
            report_mismatch("actions never seen", action_q.size(), 0);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/mcct_pkg.sv
hw/rtl/modem_command_char_translator_top.sv
hw/rtl/mcct_checker.sv
tb/modem_command_char_translator_top_tb.sv
